// File: design/kpf_pkg.sv
`timescale 1ns / 1ps

package kpf_pkg;

  // Store geometry and window limits.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RADIUS = 5;

  localparam int PIX_W   = 8;
  localparam int WORD_W  = 4 * PIX_W;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // Configuration register widths.
  localparam int RAD_W = 3;
  localparam int DIM_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [RAD_W-1:0] RST_RADIUS = RAD_W'(1);
  localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(256);
  localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(256);

  // Quadrant arithmetic widths.
  localparam int SPAN_MAX = MAX_RADIUS + 1;
  localparam int CNT_MAX  = SPAN_MAX * SPAN_MAX;
  localparam int OFF_W    = $clog2(SPAN_MAX);
  localparam int CNT_W    = $clog2(CNT_MAX + 1);
  localparam int SUM_W    = $clog2(CNT_MAX * 255 + 1);
  localparam int SQ_W     = $clog2(CNT_MAX * 255 * 255 + 1);
  localparam int VAR_W    = SQ_W + 2;
  localparam int PROD_W   = PIX_W + SUM_W;
  localparam int COORD_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  localparam int NUM_CH   = 3;
  localparam int CH_W     = 2;
  localparam int NUM_QUAD = 4;
  localparam int QUAD_W   = 2;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

endpackage

// File: design/kpf_pixel_store.sv
`timescale 1ns / 1ps

// Single-port pixel memory with a registered read.
module kpf_pixel_store (
  input  logic                      clk_i,
  input  kpf_pkg::mem_req_t         req_i,
  output logic [kpf_pkg::WORD_W-1:0] rdata_o
);

  logic [kpf_pkg::WORD_W-1:0] mem_q [kpf_pkg::STORE_DEPTH];
  logic [kpf_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/kpf_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module kpf_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [kpf_pkg::SUM_W-1:0] dividend_i,
  input  logic [kpf_pkg::CNT_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [kpf_pkg::SUM_W-1:0] quotient_o
);

  logic                          active_q;
  logic                          done_q;
  logic [kpf_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [kpf_pkg::SUM_W-1:0]     quo_q;
  logic [kpf_pkg::CNT_W-1:0]     rem_q;
  logic [kpf_pkg::CNT_W-1:0]     div_q;
  logic [kpf_pkg::CNT_W:0]       trial;
  logic                          fits;
  logic [kpf_pkg::CNT_W:0]       rem_d;

  always_comb begin
    trial = {rem_q, quo_q[kpf_pkg::SUM_W-1]};
    fits  = (trial >= {1'b0, div_q});
    rem_d = fits ? (trial - {1'b0, div_q}) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      done_q   <= 1'b0;
      cnt_q    <= kpf_pkg::DIV_CNT_W'(kpf_pkg::SUM_W);
    end else if (active_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == kpf_pkg::DIV_CNT_W'(1)) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (active_q) begin
      quo_q <= {quo_q[kpf_pkg::SUM_W-2:0], fits};
      rem_q <= rem_d[kpf_pkg::CNT_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: design/kuwahara_pixel_filter_unit.sv
`timescale 1ns / 1ps

// Channel     | Handshake                      | Payload
// ------------+--------------------------------+-------------------------------------------
// request     | start (in), busy (out)         | req_type_i, col_i, row_i, in_*_i
// result      | result_valid_o strobe          | out_alpha_o, out_red_o, out_green_o, out_blue_o
// config      | cfg_valid_i, cfg_ready_o       | cfg_index_i, cfg_data_i
//
// A request transfer takes place on a rising edge with start high and busy low.
// A load writes the store on its transfer edge, and the unit stays idle.
// A filter holds busy only through the centre read and check if the centre alpha is
// zero, and otherwise also for a scan of each quadrant in turn, one store read per pixel,
// then one shared divider producing a mean bit per cycle for each channel in turn.
// The one-cycle result strobe cannot be stalled; reset (async, active low) keeps the store.
module kuwahara_pixel_filter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           req_type_i,
  input  logic [7:0]                     col_i,
  input  logic [7:0]                     row_i,
  input  logic [7:0]                     in_alpha_i,
  input  logic [7:0]                     in_red_i,
  input  logic [7:0]                     in_green_i,
  input  logic [7:0]                     in_blue_i,
  output logic                           result_valid_o,
  output logic [7:0]                     out_alpha_o,
  output logic [7:0]                     out_red_o,
  output logic [7:0]                     out_green_o,
  output logic [7:0]                     out_blue_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kpf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kpf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDC   = 4'd1;
  localparam logic [3:0] S_CHKC  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_LAST  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_DWAIT = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_VACC  = 4'd8;
  localparam logic [3:0] S_CMP   = 4'd9;

  localparam int PIX_W   = kpf_pkg::PIX_W;
  localparam int OFF_W   = kpf_pkg::OFF_W;
  localparam int COL_W   = kpf_pkg::COL_W;
  localparam int ROW_W   = kpf_pkg::ROW_W;
  localparam int COORD_W = kpf_pkg::COORD_W;
  localparam int NUM_CH  = kpf_pkg::NUM_CH;

  // Configuration registers. The port never pushes back.
  logic [kpf_pkg::RAD_W-1:0] radius_q;
  logic [kpf_pkg::DIM_W-1:0] width_q;
  logic [kpf_pkg::DIM_W-1:0] height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= kpf_pkg::RST_RADIUS;
      width_q  <= kpf_pkg::RST_WIDTH;
      height_q <= kpf_pkg::RST_HEIGHT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        kpf_pkg::CFG_RADIUS: radius_q <= cfg_data_i[kpf_pkg::RAD_W-1:0];
        kpf_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[kpf_pkg::DIM_W-1:0];
        kpf_pkg::CFG_HEIGHT: height_q <= cfg_data_i[kpf_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Register values brought into range when a filter request is taken.
  logic [OFF_W-1:0]     rad_sel;
  logic [OFF_W:0]       span;
  logic [2*OFF_W+1:0]   span_sq;
  logic [COL_W-1:0]     wmax_sel;
  logic [ROW_W-1:0]     hmax_sel;

  always_comb begin
    if (radius_q == '0) begin
      rad_sel = OFF_W'(1);
    end else if (radius_q > kpf_pkg::RAD_W'(kpf_pkg::MAX_RADIUS)) begin
      rad_sel = OFF_W'(kpf_pkg::MAX_RADIUS);
    end else begin
      rad_sel = OFF_W'(radius_q);
    end
    span    = {1'b0, rad_sel} + 1'b1;
    span_sq = (2*OFF_W+2)'(span) * (2*OFF_W+2)'(span);

    if (width_q == '0) begin
      wmax_sel = '0;
    end else if (width_q > kpf_pkg::DIM_W'(kpf_pkg::MAX_WIDTH)) begin
      wmax_sel = COL_W'(kpf_pkg::MAX_WIDTH - 1);
    end else begin
      wmax_sel = COL_W'(width_q - 1'b1);
    end

    if (height_q == '0) begin
      hmax_sel = '0;
    end else if (height_q > kpf_pkg::DIM_W'(kpf_pkg::MAX_HEIGHT)) begin
      hmax_sel = ROW_W'(kpf_pkg::MAX_HEIGHT - 1);
    end else begin
      hmax_sel = ROW_W'(height_q - 1'b1);
    end
  end

  // Control and datapath registers.
  logic [3:0]                  state_q, state_d;
  logic [kpf_pkg::QUAD_W-1:0]  quad_q;
  logic [kpf_pkg::CH_W-1:0]    chan_q;
  logic [OFF_W-1:0]            ix_q, iy_q;
  logic                        acc_en_q;
  logic                        res_valid_q;

  logic [OFF_W-1:0]            rad_q;
  logic [kpf_pkg::CNT_W-1:0]   count_q;
  logic [COL_W-1:0]            wmax_q, cx_q;
  logic [ROW_W-1:0]            hmax_q, cy_q;
  logic [PIX_W-1:0]            alpha_q;
  logic [kpf_pkg::SUM_W-1:0]   sum_q  [NUM_CH];
  logic [kpf_pkg::SQ_W-1:0]    sq_q   [NUM_CH];
  logic [PIX_W-1:0]            mean_q [NUM_CH];
  logic [PIX_W-1:0]            best_q [NUM_CH];
  logic [kpf_pkg::PROD_W-1:0]  prod_q;
  logic [kpf_pkg::VAR_W-1:0]   var_q;
  logic [kpf_pkg::VAR_W-1:0]   min_q;
  logic [PIX_W-1:0]            out_a_q, out_r_q, out_g_q, out_b_q;

  kpf_pkg::mem_req_t           mem_req;
  logic [kpf_pkg::WORD_W-1:0]  rdata;
  logic [PIX_W-1:0]            px_chan [NUM_CH];
  logic [2*PIX_W-1:0]          px_sq   [NUM_CH];

  logic                        div_start;
  logic                        div_done;
  logic [kpf_pkg::SUM_W-1:0]   quotient;

  logic                        accept;
  logic                        alpha_zero;
  logic                        scan_last;
  logic                        chan_last;
  logic                        quad_last;
  logic                        better;

  // Window coordinates with clamping at the image edges.
  logic signed [COORD_W-1:0]   xs, ys;
  logic [COL_W-1:0]            nx;
  logic [ROW_W-1:0]            ny;

  assign accept     = start && !busy;
  assign busy       = (state_q != S_IDLE);
  assign alpha_zero = (rdata[4*PIX_W-1:3*PIX_W] == '0);
  assign scan_last  = (ix_q == rad_q) && (iy_q == rad_q);
  assign chan_last  = (chan_q == kpf_pkg::CH_W'(NUM_CH - 1));
  assign quad_last  = (quad_q == kpf_pkg::QUAD_W'(kpf_pkg::NUM_QUAD - 1));
  assign better     = (var_q < min_q);

  always_comb begin
    // The left and upper quadrants start rad pixels before the centre.
    xs = $signed({2'b00, cx_q}) + $signed(COORD_W'(ix_q))
         - (quad_q[0] ? $signed(COORD_W'(0)) : $signed(COORD_W'(rad_q)));
    ys = $signed({2'b00, cy_q}) + $signed(COORD_W'(iy_q))
         - (quad_q[1] ? $signed(COORD_W'(0)) : $signed(COORD_W'(rad_q)));

    if (xs < 0) begin
      nx = '0;
    end else if (xs > $signed({2'b00, wmax_q})) begin
      nx = wmax_q;
    end else begin
      nx = xs[COL_W-1:0];
    end

    if (ys < 0) begin
      ny = '0;
    end else if (ys > $signed({2'b00, hmax_q})) begin
      ny = hmax_q;
    end else begin
      ny = ys[ROW_W-1:0];
    end
  end

  // Red, green and blue of the word just read, with their squares.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      px_chan[c] = rdata[(NUM_CH-1-c)*PIX_W +: PIX_W];
      px_sq[c]   = (2*PIX_W)'(px_chan[c]) * (2*PIX_W)'(px_chan[c]);
    end
  end

  // Next state and the store port.
  always_comb begin
    state_d       = state_q;
    div_start     = 1'b0;
    mem_req.wr_en = 1'b0;
    mem_req.rd_en = 1'b0;
    mem_req.addr  = {row_i, col_i};
    mem_req.wdata = {in_alpha_i, in_red_i, in_green_i, in_blue_i};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i) begin
            state_d = S_RDC;
          end else begin
            mem_req.wr_en = 1'b1;
          end
        end
      end
      S_RDC: begin
        mem_req.rd_en = 1'b1;
        mem_req.addr  = {cy_q, cx_q};
        state_d       = S_CHKC;
      end
      S_CHKC: begin
        state_d = alpha_zero ? S_IDLE : S_SCAN;
      end
      S_SCAN: begin
        mem_req.rd_en = 1'b1;
        mem_req.addr  = {ny, nx};
        if (scan_last) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        div_start = 1'b1;
        state_d   = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_VACC;
      end
      S_VACC: begin
        state_d = chan_last ? S_CMP : S_DIV;
      end
      S_CMP: begin
        state_d = quad_last ? S_IDLE : S_SCAN;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      quad_q      <= '0;
      chan_q      <= '0;
      ix_q        <= '0;
      iy_q        <= '0;
      acc_en_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      // Read data arrives in the cycle after the address, so accumulation lags the scan.
      acc_en_q    <= (state_q == S_SCAN);
      res_valid_q <= ((state_q == S_CHKC) && alpha_zero) ||
                     ((state_q == S_CMP) && quad_last);

      case (state_q)
        S_CHKC: begin
          quad_q <= '0;
          ix_q   <= '0;
          iy_q   <= '0;
        end
        S_SCAN: begin
          if (ix_q == rad_q) begin
            ix_q <= '0;
            iy_q <= iy_q + 1'b1;
          end else begin
            ix_q <= ix_q + 1'b1;
          end
        end
        S_LAST: begin
          chan_q <= '0;
        end
        S_VACC: begin
          chan_q <= chan_q + 1'b1;
        end
        S_CMP: begin
          quad_q <= quad_q + 1'b1;
          ix_q   <= '0;
          iy_q   <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && accept && req_type_i) begin
      rad_q   <= rad_sel;
      count_q <= span_sq[kpf_pkg::CNT_W-1:0];
      wmax_q  <= wmax_sel;
      hmax_q  <= hmax_sel;
      cx_q    <= (col_i > wmax_sel) ? wmax_sel : col_i;
      cy_q    <= (row_i > hmax_sel) ? hmax_sel : row_i;
    end

    if (state_q == S_CHKC) begin
      alpha_q <= rdata[4*PIX_W-1:3*PIX_W];
      min_q   <= '1;
      if (alpha_zero) begin
        out_a_q <= rdata[4*PIX_W-1:3*PIX_W];
        out_r_q <= px_chan[0];
        out_g_q <= px_chan[1];
        out_b_q <= px_chan[2];
      end
    end

    // Sums are cleared just before each quadrant scan begins.
    for (int c = 0; c < NUM_CH; c++) begin
      if (state_q inside {S_CHKC, S_CMP}) begin
        sum_q[c] <= '0;
        sq_q[c]  <= '0;
      end else if (acc_en_q) begin
        sum_q[c] <= sum_q[c] + kpf_pkg::SUM_W'(px_chan[c]);
        sq_q[c]  <= sq_q[c] + kpf_pkg::SQ_W'(px_sq[c]);
      end
    end

    if (state_q == S_LAST) begin
      var_q <= '0;
    end

    if ((state_q == S_DWAIT) && div_done) begin
      mean_q[chan_q] <= quotient[PIX_W-1:0];
    end

    if (state_q == S_MUL) begin
      prod_q <= kpf_pkg::PROD_W'(mean_q[chan_q]) * kpf_pkg::PROD_W'(sum_q[chan_q]);
    end

    // The truncated mean never exceeds the true mean, so each term is non-negative.
    if (state_q == S_VACC) begin
      var_q <= var_q + kpf_pkg::VAR_W'(sq_q[chan_q]) - kpf_pkg::VAR_W'(prod_q);
    end

    if (state_q == S_CMP) begin
      if (better) begin
        min_q <= var_q;
        for (int c = 0; c < NUM_CH; c++) begin
          best_q[c] <= mean_q[c];
        end
      end
      if (quad_last) begin
        out_a_q <= alpha_q;
        out_r_q <= better ? mean_q[0] : best_q[0];
        out_g_q <= better ? mean_q[1] : best_q[1];
        out_b_q <= better ? mean_q[2] : best_q[2];
      end
    end
  end

  kpf_pixel_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  kpf_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q[chan_q]),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign result_valid_o = res_valid_q;
  assign out_alpha_o    = out_a_q;
  assign out_red_o      = out_r_q;
  assign out_green_o    = out_g_q;
  assign out_blue_o     = out_b_q;

`ifndef SYNTHESIS
  // A result is only ever produced by a filter that was under way.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without a filter in progress");

  // A filter transfer always occupies the unit on the following cycle.
  a_filter_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i) |=> busy)
    else $error("filter request did not start the sequencer");

  // A load completes on its transfer edge and never yields a result.
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !req_type_i) |=> (!busy && !result_valid_o))
    else $error("load request disturbed the sequencer");

  // A result strobe lasts a single cycle.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the Kuwahara pixel filter unit. Pixels are loaded into
// the unit's store, filter requests are issued around them, and every filtered
// pixel that comes back is compared with the value that the bench works out for
// itself from its own mirror of the store and of the geometry registers.
module tb;

  import kpf_pkg::*;

  // Rough request budget; the run stops issuing work once it is reached.
  localparam int ITEM_GOAL    = 1450;
  localparam int NUM_PHASES   = 9;
  // Requests near the end of the run are sent back to back, with no gaps.
  localparam int FINAL_STRETCH = 150;
  // Cycles without any transfer before the run is declared hung. The longest
  // filter is much shorter than this, so this leaves a wide margin.
  localparam int STALL_LIMIT  = 3000;
  // Quiet time after the last filtered pixel, longer than any filter.
  localparam int DRAIN_CYCLES = 400;
  localparam longint VAR_CEILING = 64'h7FFF_FFFF;

  // The register interface decodes two index bits; this one selects nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_FILTER = 1'b1
  } req_kind_e;

  // Store layout: alpha in the top byte, blue in the bottom one.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } argb_t;

  // Flavours of image content used to fill a window before it is filtered.
  typedef enum int {
    PAINT_NOISE,
    PAINT_FLAT,
    PAINT_GRAIN,
    PAINT_STARK
  } paint_mode_e;

  // Mirrors the pixel store and the geometry registers, and keeps the filtered
  // pixels still owed by the unit in request order.
  class kuwahara_scoreboard;
    argb_t      store [STORE_DEPTH];
    bit         loaded [STORE_DEPTH];
    logic [2:0] radius;
    logic [8:0] width;
    logic [8:0] height;
    argb_t      pending_pixels [$];
    int         fail_count;

    function new();
      radius     = RST_RADIUS;
      width      = RST_WIDTH;
      height     = RST_HEIGHT;
      fail_count = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_RADIUS: radius = data[2:0];
        CFG_WIDTH:  width  = data;
        CFG_HEIGHT: height = data;
        default: ;
      endcase
    endfunction

    function int span_radius();
      if (radius == 0) return 1;
      if (radius > MAX_RADIUS) return MAX_RADIUS;
      return radius;
    endfunction

    function int dim_limit(logic [8:0] v, int top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function int clamp_hi(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    // Centre after clamping to the image, and the rectangle of store entries
    // that a filter around it may read.
    function void footprint(logic [7:0] col, logic [7:0] row, output int cx, output int cy,
                            output int xlo, output int xhi, output int ylo, output int yhi);
      int rad;
      int wmax;
      int hmax;
      rad  = span_radius();
      wmax = dim_limit(width, MAX_WIDTH) - 1;
      hmax = dim_limit(height, MAX_HEIGHT) - 1;
      cx   = clamp_hi(col, wmax);
      cy   = clamp_hi(row, hmax);
      xlo  = clamp_hi(cx - rad, wmax);
      xhi  = clamp_hi(cx + rad, wmax);
      ylo  = clamp_hi(cy - rad, hmax);
      yhi  = clamp_hi(cy + rad, hmax);
    endfunction

    // Least-variance quadrant mean around (cx, cy); a transparent centre is
    // returned as it stands.
    function argb_t quadrant_filter(int cx, int cy);
      argb_t  centre;
      argb_t  res;
      argb_t  p;
      int     rad;
      int     wmax;
      int     hmax;
      int     x0;
      int     y0;
      int     nx;
      int     ny;
      longint s [3];
      longint sq [3];
      longint mean [3];
      longint v;
      longint cnt;
      longint spread;
      longint best_spread;
      centre = store[cy * MAX_WIDTH + cx];
      res    = centre;
      if (centre.alpha == 0) return res;
      rad  = span_radius();
      wmax = dim_limit(width, MAX_WIDTH) - 1;
      hmax = dim_limit(height, MAX_HEIGHT) - 1;
      cnt  = (rad + 1) * (rad + 1);
      best_spread = VAR_CEILING;
      for (int q = 0; q < 4; q++) begin
        x0 = (q & 1) ? 0 : -rad;
        y0 = (q & 2) ? 0 : -rad;
        for (int c = 0; c < 3; c++) begin
          s[c]  = 0;
          sq[c] = 0;
        end
        for (int dy = y0; dy <= y0 + rad; dy++) begin
          ny = clamp_hi(cy + dy, hmax);
          for (int dx = x0; dx <= x0 + rad; dx++) begin
            nx = clamp_hi(cx + dx, wmax);
            p  = store[ny * MAX_WIDTH + nx];
            for (int c = 0; c < 3; c++) begin
              v      = (p >> (16 - 8 * c)) & 32'hFF;
              s[c]  += v;
              sq[c] += v * v;
            end
          end
        end
        spread = 0;
        for (int c = 0; c < 3; c++) begin
          mean[c] = s[c] / cnt;
          spread += sq[c] - mean[c] * s[c];
        end
        // Ties keep the earlier quadrant.
        if (spread < best_spread) begin
          best_spread = spread;
          res.red     = mean[0][7:0];
          res.green   = mean[1][7:0];
          res.blue    = mean[2][7:0];
        end
      end
      return res;
    endfunction

    function void note_request(req_kind_e kind, logic [7:0] col, logic [7:0] row, argb_t px);
      int cx;
      int cy;
      int xlo;
      int xhi;
      int ylo;
      int yhi;
      if (kind == REQ_LOAD) begin
        store[{row, col}]  = px;
        loaded[{row, col}] = 1'b1;
      end else begin
        footprint(col, row, cx, cy, xlo, xhi, ylo, yhi);
        pending_pixels.push_back(quadrant_filter(cx, cy));
      end
    endfunction

    function void compare_result(argb_t got);
      argb_t want;
      string field_name [4];
      field_name = '{"out_alpha", "out_red", "out_green", "out_blue"};
      if (pending_pixels.size() == 0) begin
        $error("filtered pixel %h arrived with no filter request outstanding", got);
        fail_count++;
        return;
      end
      want = pending_pixels.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got[31 - 8 * i -: 8] !== want[31 - 8 * i -: 8]) begin
          $error("%s mismatch: expected %0d, actual %0d", field_name[i],
                 want[31 - 8 * i -: 8], got[31 - 8 * i -: 8]);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  req_type_i;
  logic [7:0]            col_i;
  logic [7:0]            row_i;
  logic [7:0]            in_alpha_i;
  logic [7:0]            in_red_i;
  logic [7:0]            in_green_i;
  logic [7:0]            in_blue_i;
  logic                  result_valid_o;
  logic [7:0]            out_alpha_o;
  logic [7:0]            out_red_o;
  logic [7:0]            out_green_o;
  logic [7:0]            out_blue_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  kuwahara_scoreboard sb;
  int n_items     = 0;
  int quiet_cycles = 0;
  bit idling_on   = 1'b1;

  kuwahara_pixel_filter_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .col_i          (col_i),
    .row_i          (row_i),
    .in_alpha_i     (in_alpha_i),
    .in_red_i       (in_red_i),
    .in_green_i     (in_green_i),
    .in_blue_i      (in_blue_i),
    .result_valid_o (result_valid_o),
    .out_alpha_o    (out_alpha_o),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Filtered pixels are strobed for a single cycle, so they are taken at every
  // rising edge on which the strobe is high. The same process watches for a
  // hang: any transfer on any of the three channels restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        sb.compare_result(argb_t'{out_alpha_o, out_red_o, out_green_o, out_blue_o});
      end
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("kuwahara_pixel_filter_unit regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic bit in_final_stretch();
    return n_items >= ITEM_GOAL - FINAL_STRETCH;
  endfunction

  function automatic logic [7:0] drift(logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 4)) - 2;
    if (t < 0) return 8'd0;
    if (t > 255) return 8'd255;
    return 8'(t);
  endfunction

  // One pixel of window content. Alpha is mostly random, with opaque and fully
  // transparent values made common so that both filter paths are taken often.
  function automatic argb_t paint(paint_mode_e mode, argb_t base);
    argb_t px;
    px = argb_t'($urandom);
    case ($urandom_range(0, 7))
      0: px.alpha = 8'h00;
      1: px.alpha = 8'hFF;
      default: ;
    endcase
    case (mode)
      PAINT_FLAT: begin
        px.red   = base.red;
        px.green = base.green;
        px.blue  = base.blue;
      end
      PAINT_GRAIN: begin
        px.red   = base.red ^ 8'($urandom_range(0, 7));
        px.green = base.green ^ 8'($urandom_range(0, 7));
        px.blue  = base.blue ^ 8'($urandom_range(0, 7));
      end
      PAINT_STARK: begin
        px.red   = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        px.green = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        px.blue  = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      end
      default: ;
    endcase
    return px;
  endfunction

  // Presents one request and holds it until the unit takes it. The task is
  // entered and left at a falling edge; start stays high on the way out, so
  // the caller must either present the next request at once or lower it.
  task automatic send_request(input req_kind_e kind, input logic [7:0] col,
                              input logic [7:0] row, input argb_t px);
    bit taken;
    taken = 1'b0;
    if (idling_on && !in_final_stretch() && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    req_type_i = kind;
    col_i      = col;
    row_i      = row;
    in_alpha_i = px.alpha;
    in_red_i   = px.red;
    in_green_i = px.green;
    in_blue_i  = px.blue;
    start      = 1'b1;
    while (!taken) begin
      @(posedge clk_i);
      if (!busy) begin
        taken = 1'b1;
      end else if (idling_on && !in_final_stretch() && $urandom_range(0, 31) == 0) begin
        // Withdraw the request for a while as the unit works, so that gaps also
        // land in the middle of a filter.
        @(negedge clk_i);
        start = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        start = 1'b1;
      end
    end
    sb.note_request(kind, col, row, px);
    n_items++;
    @(negedge clk_i);
  endtask

  // Loads the centre anew if asked and any never-written part of the window
  // around (col, row), then filters there. A transparent centre only needs the centre itself.
  task automatic filter_pixel_at(input logic [7:0] col, input logic [7:0] row,
                                 input paint_mode_e mode, input int centre_alpha,
                                 input bit fresh_centre);
    int    cx;
    int    cy;
    int    xlo;
    int    xhi;
    int    ylo;
    int    yhi;
    argb_t base;
    argb_t px;
    base = argb_t'($urandom);
    sb.footprint(col, row, cx, cy, xlo, xhi, ylo, yhi);
    if (fresh_centre || !sb.loaded[cy * MAX_WIDTH + cx]) begin
      px = paint(mode, base);
      if (centre_alpha >= 0) px.alpha = centre_alpha[7:0];
      send_request(REQ_LOAD, 8'(cx), 8'(cy), px);
    end
    if (sb.store[cy * MAX_WIDTH + cx].alpha != 0) begin
      for (int y = ylo; y <= yhi; y++) begin
        for (int x = xlo; x <= xhi; x++) begin
          if (!sb.loaded[y * MAX_WIDTH + x]) send_request(REQ_LOAD, 8'(x), 8'(y), paint(mode, base));
        end
      end
    end
    // The colour fields mean nothing on a filter request, so they carry noise.
    send_request(REQ_FILTER, col, row, argb_t'($urandom));
  endtask

  // Rewrites the geometry registers once the unit has gone quiet: nothing is
  // owed and busy is low. The bench then idles before the first write.
  task automatic program_geometry(input logic [8:0] rad, input logic [8:0] w,
                                  input logic [8:0] h, input bit poke_spare);
    logic [CFG_IDX_W-1:0]  reg_idx [4];
    logic [CFG_DATA_W-1:0] reg_val [4];
    int                    n_regs;
    reg_idx[0] = CFG_RADIUS;
    reg_val[0] = rad;
    reg_idx[1] = CFG_WIDTH;
    reg_val[1] = w;
    reg_idx[2] = CFG_HEIGHT;
    reg_val[2] = h;
    reg_idx[3] = CFG_SPARE;
    reg_val[3] = 9'h1FF;
    n_regs     = poke_spare ? 4 : 3;
    start = 1'b0;
    @(posedge clk_i);
    while (sb.pending_pixels.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    for (int i = 0; i < n_regs; i++) begin
      cfg_index_i = reg_idx[i];
      cfg_data_i  = reg_val[i];
      cfg_valid_i = 1'b1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.note_config(reg_idx[i], reg_val[i]);
      @(negedge clk_i);
    end
    cfg_valid_i = 1'b0;
  endtask

  // One geometry setting followed by random traffic: mostly filters that walk
  // slowly over the image, some that jump anywhere (far outside small images
  // too), and stray loads at random places in the store.
  task automatic run_phase(input logic [8:0] rad, input logic [8:0] w, input logic [8:0] h,
                           input bit poke_spare, input int phase_no, input int first_random);
    int         target;
    int         sel;
    logic [7:0] col;
    logic [7:0] row;
    program_geometry(rad, w, h, poke_spare);
    idling_on = ($urandom_range(0, 2) != 0);
    target    = first_random + (ITEM_GOAL - first_random) * (phase_no + 1) / NUM_PHASES;
    col       = 8'($urandom);
    row       = 8'($urandom);
    while (n_items < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        send_request(REQ_LOAD, 8'($urandom), 8'($urandom), paint(PAINT_NOISE, argb_t'(0)));
      end else begin
        if (sel < 25) begin
          col = 8'($urandom);
          row = 8'($urandom);
        end else begin
          col = drift(col);
          row = drift(row);
        end
        filter_pixel_at(col, row, paint_mode_e'($urandom_range(0, 3)), -1,
                        $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin
    int first_random;
    sb          = new();
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_type_i  = REQ_LOAD;
    col_i       = '0;
    row_i       = '0;
    in_alpha_i  = '0;
    in_red_i    = '0;
    in_green_i  = '0;
    in_blue_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_RADIUS;
    cfg_data_i  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed cases under the reset geometry: a transparent centre passed
    // straight through, a flat opaque corner where every quadrant ties, a
    // window of full and empty channels next to the transparent pixel, and plain noise.
    filter_pixel_at(8'd0, 8'd0, PAINT_FLAT, 0, 1'b1);
    filter_pixel_at(8'd255, 8'd255, PAINT_FLAT, 255, 1'b1);
    filter_pixel_at(8'd1, 8'd1, PAINT_STARK, 8'h80, 1'b1);
    filter_pixel_at(8'd128, 8'd7, PAINT_NOISE, -1, 1'b0);
    filter_pixel_at(8'd0, 8'd0, PAINT_NOISE, -1, 1'b0);
    first_random = n_items;

    // Geometry settings: out-of-range radius codes in both directions, zero
    // and oversized image sizes, single-row and single-column images, and the
    // full image at the largest radius. The end of the last setting runs with no gaps.
    run_phase(9'd5, 9'd16, 9'd16, 1'b0, 0, first_random);
    run_phase(9'd0, 9'd0, 9'd0, 1'b1, 1, first_random);
    run_phase(9'h1FF, 9'd511, 9'd3, 1'b0, 2, first_random);
    run_phase(9'd2, 9'd256, 9'd256, 1'b0, 3, first_random);
    run_phase(9'd3, 9'd9, 9'd40, 1'b0, 4, first_random);
    run_phase(9'd6, 9'd1, 9'd256, 1'b0, 5, first_random);
    run_phase(9'd4, 9'd300, 9'd17, 1'b0, 6, first_random);
    run_phase(9'd5, 9'd256, 9'd256, 1'b0, 7, first_random);
    run_phase(9'd1, 9'd2, 9'd2, 1'b0, 8, first_random);

    start = 1'b0;
    @(posedge clk_i);
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    // Anything strobed after this point would be a stray result.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending_pixels.size() == 0) begin
      $display("kuwahara_pixel_filter_unit regression: pass");
    end else begin
      $display("kuwahara_pixel_filter_unit regression: fail");
    end
    $finish;
  end

endmodule
